[hdl/timed_wait_list_core_macros.svh]
// Assertion macros shared by the timed wait list checker.
`ifndef TIMED_WAIT_LIST_CORE_MACROS_SVH
`define TIMED_WAIT_LIST_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/twl_pkg.sv]
// Types and constants of the timed wait list.
package twl_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int ID_W      = 16;
	localparam int WAIT_W    = 16;
	localparam int OP_W      = 3;
	localparam int RCNT_W    = 5;
	localparam int STAT_W    = 2;

	localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
	localparam logic [OP_W-1:0] OP_TICK      = 3'd1;
	localparam logic [OP_W-1:0] OP_REL_FIRST = 3'd2;
	localparam logic [OP_W-1:0] OP_REL_ALL   = 3'd3;
	localparam logic [OP_W-1:0] OP_FIND      = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_WALK
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [WAIT_W-1:0] wait_cnt;
	} entry_t;

	typedef struct packed {
		logic              released_valid;
		logic [ID_W-1:0]   released_id;
		logic              by_timer;
		logic [RCNT_W-1:0] release_count;
		logic              found;
		logic [WAIT_W-1:0] found_wait;
		logic [STAT_W-1:0] status;
		logic              last;
	} rsp_t;

endpackage

[hdl/twl_store.sv]
// Entry memory of the wait list: one write port, one registered read port.
module twl_store import twl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  entry_t                                     wr_data,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output entry_t                                     rd_data
);

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read data holds while no read is issued, so a stalled walk keeps its entry.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/timed_wait_list_core.sv]
// Add, unknown codes and releases on an empty list give a single result, registered from the
// start state, which waits there while a stalled result holds the output. One request at a time.
// Tick, find and the other releases read n entries through the registered read port, one a
// cycle unless a stalled result pauses the walk (n is the count, 1 for release first); a find
// that matches ends the walk at that entry.
// The asynchronous reset empties the list and drops the result valid; the memory is not cleared.
module timed_wait_list_core import twl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic [OP_W-1:0]   opcode,
	input  logic [ID_W-1:0]   thread_id,
	input  logic [WAIT_W-1:0] wait_ticks,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              released_valid,
	output logic [ID_W-1:0]   released_id,
	output logic              by_timer,
	output logic [RCNT_W-1:0] release_count,
	output logic              found,
	output logic [WAIT_W-1:0] found_wait,
	output logic [STAT_W-1:0] status,
	output logic              last
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	// Physical slot of a list position in the circular buffer.
	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	state_t            state_q, state_d;
	logic [OP_W-1:0]   op_q;
	logic [ID_W-1:0]   tid_q;
	logic [WAIT_W-1:0] wt_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  lim_q;
	logic [CNT_W-1:0]  iss_q;
	logic [CNT_W-1:0]  prc_q;
	logic [CNT_W-1:0]  keep_q;
	logic [RCNT_W-1:0] rel_q;
	logic              hold_v_q;
	logic [ID_W-1:0]   hold_id_q;
	logic              hold_timer_q;
	logic [RCNT_W-1:0] hold_cnt_q;
	logic              pend_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_q, rsp_d;

	logic              cmd_take;
	logic              out_free;
	logic              ld_out;
	logic              single;
	logic              full;
	logic              is_rel_op;
	logic              expired;
	logic              rel_ent;
	logic              hit;
	logic              need_out;
	logic              consume;
	logic              walk_done;
	logic              issue;
	logic              finish;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;
	entry_t            ent;

	twl_store #(.DEPTH(DEPTH)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (phys(head_q, iss_q)),
		.rd_data (ent)
	);

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign is_rel_op = (op_q == OP_REL_FIRST) || (op_q == OP_REL_ALL);
	assign single    = (op_q == OP_ADD) || (is_rel_op && cnt_q == '0) ||
		!((op_q == OP_TICK) || is_rel_op || (op_q == OP_FIND));

	assign expired   = (op_q == OP_TICK) && (ent.wait_cnt == WAIT_W'(1));
	assign rel_ent   = expired || is_rel_op;
	assign hit       = (op_q == OP_FIND) && (ent.id == tid_q);
	assign need_out  = (rel_ent && hold_v_q) || hit;
	assign consume   = (state_q == S_WALK) && pend_s1 && (!need_out || out_free);
	assign walk_done = (state_q == S_WALK) && !pend_s1 && (prc_q == lim_q);
	// A find that matches ends the walk, so no further read is issued behind it.
	assign issue     = (state_q == S_WALK) && (iss_q != lim_q) &&
		(!pend_s1 || (consume && !hit));
	assign finish    = (walk_done && out_free) || (consume && hit);

	// Result and memory write selection.
	always_comb begin
		ld_out  = 1'b0;
		rsp_d   = '0;
		wr_en   = 1'b0;
		wr_addr = phys(head_q, keep_q);
		wr_data = '{id: ent.id, wait_cnt: ent.wait_cnt - WAIT_W'(ent.wait_cnt != '0)};
		unique case (state_q)
			S_IDLE: begin
			end
			S_START: begin
				if (single && out_free) begin
					ld_out     = 1'b1;
					rsp_d.last = 1'b1;
					if (op_q == OP_ADD) begin
						if (full) begin
							rsp_d.status = STAT_FULL;
						end else begin
							wr_en   = 1'b1;
							wr_addr = phys(head_q, cnt_q);
							wr_data = '{id: tid_q, wait_cnt: wt_q};
						end
					end else if (is_rel_op) begin
						rsp_d.status = STAT_EMPTY;
					end
				end
			end
			S_WALK: begin
				if (consume) begin
					if (rel_ent && hold_v_q) begin
						ld_out               = 1'b1;
						rsp_d.released_valid = 1'b1;
						rsp_d.released_id    = hold_id_q;
						rsp_d.by_timer       = hold_timer_q;
						rsp_d.release_count  = hold_cnt_q;
					end
					if (hit) begin
						ld_out           = 1'b1;
						rsp_d.found      = 1'b1;
						rsp_d.found_wait = ent.wait_cnt;
						rsp_d.last       = 1'b1;
					end
					if ((op_q == OP_TICK) && !expired) begin
						wr_en = 1'b1;
					end
				end
				if (walk_done && out_free) begin
					ld_out     = 1'b1;
					rsp_d.last = 1'b1;
					if (hold_v_q) begin
						rsp_d.released_valid = 1'b1;
						rsp_d.released_id    = hold_id_q;
						rsp_d.by_timer       = hold_timer_q;
						rsp_d.release_count  = hold_cnt_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_take) begin
					state_d = S_START;
				end
			end
			S_START: begin
				if (!single) begin
					state_d = S_WALK;
				end else if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_WALK: begin
				if (finish) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			cnt_q       <= '0;
			lim_q       <= '0;
			iss_q       <= '0;
			prc_q       <= '0;
			keep_q      <= '0;
			rel_q       <= '0;
			hold_v_q    <= 1'b0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_out) begin
				rsp_valid_q <= 1'b1;
			end else if (out_free) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == S_START) begin
				if (single) begin
					if (out_free && (op_q == OP_ADD) && !full) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end else begin
					lim_q    <= (op_q == OP_REL_FIRST) ? CNT_W'(1) : cnt_q;
					iss_q    <= '0;
					prc_q    <= '0;
					keep_q   <= '0;
					rel_q    <= '0;
					hold_v_q <= 1'b0;
					pend_s1  <= 1'b0;
				end
			end
			if (state_q == S_WALK) begin
				if (issue) begin
					iss_q   <= iss_q + CNT_W'(1);
					pend_s1 <= 1'b1;
				end else if (consume) begin
					pend_s1 <= 1'b0;
				end
				if (consume) begin
					prc_q <= prc_q + CNT_W'(1);
					if (rel_ent) begin
						hold_v_q <= 1'b1;
						rel_q    <= rel_q + RCNT_W'(1);
					end
					if ((op_q == OP_TICK) && !expired) begin
						keep_q <= keep_q + CNT_W'(1);
					end
				end
				if (walk_done && out_free) begin
					priority if (op_q == OP_TICK) begin
						cnt_q <= keep_q;
					end else if (op_q == OP_REL_FIRST) begin
						head_q <= (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
						cnt_q  <= cnt_q - CNT_W'(1);
					end else if (op_q == OP_REL_ALL) begin
						cnt_q <= '0;
					end
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			op_q  <= opcode;
			tid_q <= thread_id;
			wt_q  <= wait_ticks;
		end
		if (consume && rel_ent) begin
			hold_id_q    <= ent.id;
			hold_timer_q <= expired;
			hold_cnt_q   <= rel_q + RCNT_W'(1);
		end
		if (ld_out) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign released_valid = rsp_q.released_valid;
	assign released_id    = rsp_q.released_id;
	assign by_timer       = rsp_q.by_timer;
	assign release_count  = rsp_q.release_count;
	assign found          = rsp_q.found;
	assign found_wait     = rsp_q.found_wait;
	assign status         = rsp_q.status;
	assign last           = rsp_q.last;

endmodule

[hdl/twl_checker.sv]
// Port-level checks of the timed wait list, bound to the top level.
`include "timed_wait_list_core_macros.svh"

module twl_checker import twl_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_stall,
	input logic [OP_W-1:0]   opcode,
	input logic [ID_W-1:0]   thread_id,
	input logic [WAIT_W-1:0] wait_ticks,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input logic              released_valid,
	input logic [ID_W-1:0]   released_id,
	input logic              by_timer,
	input logic [RCNT_W-1:0] release_count,
	input logic              found,
	input logic [WAIT_W-1:0] found_wait,
	input logic [STAT_W-1:0] status,
	input logic              last
);

	// A stalled result keeps its value.
	`TWL_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(released_id) && $stable(release_count) && $stable(last), "stalled result changed")

	// Only one request is in work: a taken request closes the request channel.
	`TWL_ASSERT_NXT(a_one_request, clk, arst_n, cmd_valid && !cmd_stall, cmd_stall, "request taken while another is in work")

	// A result that releases nothing carries no timer mark and no count.
	`TWL_ASSERT_IMP(a_no_release, clk, arst_n, rsp_valid && !released_valid, !by_timer && release_count == '0, "release fields set without a release")

	// A find hit is a single, final result with ok status.
	`TWL_ASSERT_IMP(a_find_hit, clk, arst_n, rsp_valid && found, !released_valid && last && status == STAT_OK, "malformed find result")

endmodule

bind timed_wait_list_core twl_checker u_twl_checker (.*);
